>>> rtl/core/md_tag_generator_assert.svh
// assertion macros shared by the md tag generator modules
`ifndef MD_TAG_GENERATOR_ASSERT_SVH
`define MD_TAG_GENERATOR_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define MDTG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// condition that implies another in the same cycle
`define MDTG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that implies another in the next cycle
`define MDTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mdtg_pkg.sv
// shared types and constants of the md tag generator
package mdtg_pkg;

    // alignment column kinds
    localparam logic [1:0] KIND_MATCH  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    // ascii characters written by the block
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_CARET = 8'h5E;

    // what one column asks the back end to write, in this order
    typedef struct packed {
        logic       has_pre;   // run count before the column
        logic       has_caret; // deletion group opener
        logic       has_base;  // reference base
        logic       has_post;  // closing count of the tag
        logic [7:0] base;
    } cmd_flags_t;

endpackage

>>> rtl/core/mdtg_front.sv
// front end: accepts columns, keeps the match run count, classifies output
`include "md_tag_generator_assert.svh"

module mdtg_front
    import mdtg_pkg::*;
#(
    parameter int COUNT_WIDTH = 20,
    localparam int NDIG = (COUNT_WIDTH * 30103) / 100000 + 1,
    localparam int DIG_IDX_W = $clog2(NDIG)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           column_kind,
    input  logic [7:0]           read_base,
    input  logic [7:0]           ref_base,
    input  logic                 new_op,
    input  logic                 last_column,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_flags_t           q_flags,
    output logic [DIG_IDX_W-1:0] q_top,
    output logic [4*NDIG-1:0]    q_bcd
);

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [4*NDIG-1:0]      bcd_reg, bcd_next;
    logic                   in_del_reg, in_del_next;

    logic                   accept;
    logic                   is_match, is_del, is_eq, grp_start, mismatch;
    logic                   saturated, do_inc;
    logic [4*NDIG-1:0]      bcd_inc, bcd_after, bcd_print;
    logic [3:0]             dig;
    logic                   carry;
    logic                   bcd_ok;
    logic [DIG_IDX_W-1:0]   top;

    assign full   = q_full;
    assign accept = push && !q_full;

    // column classification
    assign is_match  = (column_kind == KIND_MATCH);
    assign is_del    = (column_kind == KIND_DELETE);
    assign is_eq     = (read_base == ref_base);
    assign mismatch  = is_match && !is_eq;
    assign grp_start = is_del && (new_op || !in_del_reg);
    assign saturated = (count_reg == {COUNT_WIDTH{1'b1}});
    assign do_inc    = is_match && is_eq && !saturated;

    // decimal increment of the run count, carry ripples over the digits
    always_comb
    begin
        carry   = 1'b1;
        bcd_inc = bcd_reg;
        for (int i = 0; i < NDIG; i++)
        begin
            dig = bcd_reg[i*4 +: 4];
            if (carry)
                bcd_inc[i*4 +: 4] = (dig == 4'd9) ? 4'd0 : dig + 4'd1;
            carry = carry && (dig == 4'd9);
        end
    end

    assign bcd_after = do_inc ? bcd_inc : bcd_reg;
    // a count written before the column is the old one, otherwise the updated one
    assign bcd_print = (mismatch || grp_start) ? bcd_reg : bcd_after;

    // most significant nonzero digit of the printed count
    always_comb
    begin
        top = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_print[i*4 +: 4] != 4'd0)
                top = DIG_IDX_W'(i);
        end
    end

    // command toward the back end
    always_comb
    begin
        q_flags.has_pre   = mismatch || grp_start;
        q_flags.has_caret = grp_start;
        q_flags.has_base  = mismatch || is_del;
        q_flags.has_post  = last_column;
        q_flags.base      = ref_base;
    end

    assign q_push = accept && (mismatch || is_del || last_column);
    assign q_top  = top;
    assign q_bcd  = bcd_print;

    // next run state
    always_comb
    begin
        count_next  = count_reg;
        bcd_next    = bcd_reg;
        in_del_next = in_del_reg;
        if (accept)
        begin
            in_del_next = is_del && !last_column;
            if (last_column || mismatch || grp_start)
            begin
                count_next = '0;
                bcd_next   = '0;
            end
            else if (do_inc)
            begin
                count_next = count_reg + COUNT_WIDTH'(1);
                bcd_next   = bcd_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            bcd_reg    <= '0;
            in_del_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            bcd_reg    <= bcd_next;
            in_del_reg <= in_del_next;
        end
    end

    // every decimal digit stays a valid digit
    always_comb
    begin
        bcd_ok = 1'b1;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] > 4'd9)
                bcd_ok = 1'b0;
        end
    end

    `MDTG_ASSERT_ALWAYS(a_bcd_digits, bcd_ok, "decimal run count holds a bad digit")
    `MDTG_ASSERT_ALWAYS(a_bcd_zero, ((count_reg == '0) == (bcd_reg == '0)),
        "binary and decimal run counts disagree on zero")

endmodule

>>> rtl/core/mdtg_cmd_fifo.sv
// short command queue between the front and back ends
`include "md_tag_generator_assert.svh"

module mdtg_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + (AW+1)'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - (AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    `MDTG_ASSERT_ALWAYS(a_fill_bound, (count_reg <= (AW+1)'(DEPTH)),
        "command queue fill count out of range")
    `MDTG_ASSERT_IMPLY(a_no_overflow, wr_en, !full, "command written into a full queue")
    `MDTG_ASSERT_IMPLY(a_no_underflow, rd_en, !empty, "command taken from an empty queue")

endmodule

>>> rtl/core/mdtg_back.sv
// back end: expands commands into md tag bytes and holds the output beat
`include "md_tag_generator_assert.svh"

module mdtg_back
    import mdtg_pkg::*;
#(
    parameter int COUNT_WIDTH = 20,
    localparam int NDIG = (COUNT_WIDTH * 30103) / 100000 + 1,
    localparam int DIG_IDX_W = $clog2(NDIG)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  cmd_flags_t           q_flags,
    input  logic [DIG_IDX_W-1:0] q_top,
    input  logic [4*NDIG-1:0]    q_bcd,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           md_byte,
    output logic                 last_of_item,
    output logic                 end_of_tag
);

    typedef enum logic [1:0] {
        PH_PRE,
        PH_CARET,
        PH_BASE,
        PH_POST
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic                 busy_reg, busy_next;
    logic [DIG_IDX_W-1:0] dig_reg, dig_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           byte_reg;
    logic                 last_reg, eot_reg;

    phase_t               cur_phase, nxt_phase;
    logic [DIG_IDX_W-1:0] cur_dig;
    logic                 has_nxt, phase_done, cmd_done, zero_num, step;
    logic [3:0]           digit;
    logic [7:0]           cur_byte;

    // output register moves on when empty or being taken and a command is queued
    assign step  = (!out_valid_reg || pop) && !q_empty;
    assign empty = !out_valid_reg;

    // position within the head command
    always_comb
    begin
        if (busy_reg)
            cur_phase = phase_reg;
        else if (q_flags.has_pre)
            cur_phase = PH_PRE;
        else if (q_flags.has_caret)
            cur_phase = PH_CARET;
        else if (q_flags.has_base)
            cur_phase = PH_BASE;
        else
            cur_phase = PH_POST;
    end

    assign cur_dig  = busy_reg ? dig_reg : q_top;
    // closing count after an earlier count in the same column is always zero
    assign zero_num = (cur_phase == PH_POST) && q_flags.has_pre;
    assign digit    = zero_num ? 4'd0 : q_bcd[cur_dig*4 +: 4];

    // byte for this beat
    always_comb
    begin
        case (cur_phase)
            PH_PRE:   cur_byte = CHAR_ZERO + {4'd0, digit};
            PH_CARET: cur_byte = CHAR_CARET;
            PH_BASE:  cur_byte = q_flags.base;
            PH_POST:  cur_byte = CHAR_ZERO + {4'd0, digit};
            default:  cur_byte = CHAR_ZERO;
        endcase
    end

    // following phase of the same command
    always_comb
    begin
        has_nxt   = 1'b0;
        nxt_phase = PH_POST;
        case (cur_phase)
            PH_PRE:
            begin
                if (q_flags.has_caret)
                begin
                    has_nxt   = 1'b1;
                    nxt_phase = PH_CARET;
                end
                else if (q_flags.has_base)
                begin
                    has_nxt   = 1'b1;
                    nxt_phase = PH_BASE;
                end
                else if (q_flags.has_post)
                begin
                    has_nxt   = 1'b1;
                    nxt_phase = PH_POST;
                end
            end
            PH_CARET:
            begin
                if (q_flags.has_base)
                begin
                    has_nxt   = 1'b1;
                    nxt_phase = PH_BASE;
                end
                else if (q_flags.has_post)
                begin
                    has_nxt   = 1'b1;
                    nxt_phase = PH_POST;
                end
            end
            PH_BASE:
            begin
                if (q_flags.has_post)
                begin
                    has_nxt   = 1'b1;
                    nxt_phase = PH_POST;
                end
            end
            default:
            begin
                has_nxt   = 1'b0;
                nxt_phase = PH_POST;
            end
        endcase
    end

    assign phase_done = !((cur_phase == PH_PRE || cur_phase == PH_POST) && !zero_num
                          && (cur_dig != '0));
    assign cmd_done   = phase_done && !has_nxt;
    assign q_pop      = step && cmd_done;

    // sequencer next state
    always_comb
    begin
        phase_next     = phase_reg;
        busy_next      = busy_reg;
        dig_next       = dig_reg;
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b0;
        if (step)
        begin
            out_valid_next = 1'b1;
            if (cmd_done)
                busy_next = 1'b0;
            else if (phase_done)
            begin
                busy_next  = 1'b1;
                phase_next = nxt_phase;
                dig_next   = (nxt_phase == PH_POST && q_flags.has_pre) ? '0 : q_top;
            end
            else
            begin
                busy_next  = 1'b1;
                phase_next = cur_phase;
                dig_next   = cur_dig - DIG_IDX_W'(1);
            end
        end
    end

    // sequencer state and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PRE;
            busy_reg      <= 1'b0;
            dig_reg       <= '0;
            out_valid_reg <= 1'b0;
            byte_reg      <= '0;
            last_reg      <= 1'b0;
            eot_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            busy_reg      <= busy_next;
            dig_reg       <= dig_next;
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                byte_reg <= cur_byte;
                last_reg <= cmd_done;
                eot_reg  <= cmd_done && q_flags.has_post;
            end
        end
    end

    assign md_byte      = byte_reg;
    assign last_of_item = last_reg;
    assign end_of_tag   = eot_reg;

    `MDTG_ASSERT_IMPLY(a_digit_range,
        step && (cur_phase == PH_PRE || cur_phase == PH_POST), (digit <= 4'd9),
        "count digit out of decimal range")
    `MDTG_ASSERT_IMPLY(a_busy_has_cmd, busy_reg, !q_empty,
        "sequencer mid command with no command queued")
    `MDTG_ASSERT_NEXT(a_eot_is_last, step && cmd_done && q_flags.has_post,
        last_reg && eot_reg, "end of tag beat not marked as last of item")

endmodule

>>> rtl/core/md_tag_generator.sv
// top level of the sam md tag generator
// Takes one alignment column per beat and writes the MD tag text as ASCII bytes,
// one byte per result beat. Matching columns other than the last only count and
// write nothing, so columns are taken one per cycle while the command queue has
// room. The back end expands a column that writes text into its bytes (decimal
// digits of the run count, '^', the reference base, the closing count), one byte
// per cycle while the output beat is free or taken; the four entry command queue
// lets the front end keep taking columns meanwhile. The run count is kept in binary
// and decimal digits, saturates at 2**COUNT_WIDTH - 1, and is written with at least
// one digit. last_of_item marks the last byte of a column, end_of_tag the closing count.
module md_tag_generator
    import mdtg_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] column_kind,
    input  logic [7:0] read_base,
    input  logic [7:0] ref_base,
    input  logic       new_op,
    input  logic       last_column,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] md_byte,
    output logic       last_of_item,
    output logic       end_of_tag
);

    localparam int NDIG      = (COUNT_WIDTH * 30103) / 100000 + 1;
    localparam int DIG_IDX_W = $clog2(NDIG);
    localparam int FLAGS_W   = $bits(cmd_flags_t);
    localparam int CMD_W     = FLAGS_W + DIG_IDX_W + 4 * NDIG;
    localparam int Q_DEPTH   = 4;

    logic                 q_push, q_full, q_pop, q_empty;
    cmd_flags_t           in_flags, out_flags;
    logic [DIG_IDX_W-1:0] in_top, out_top;
    logic [4*NDIG-1:0]    in_bcd, out_bcd;
    logic [CMD_W-1:0]     q_wr_data, q_rd_data;

    // column intake and run count
    mdtg_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .column_kind(column_kind),
        .read_base  (read_base),
        .ref_base   (ref_base),
        .new_op     (new_op),
        .last_column(last_column),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_flags    (in_flags),
        .q_top      (in_top),
        .q_bcd      (in_bcd)
    );

    assign q_wr_data = {in_flags, in_top, in_bcd};

    // command queue
    mdtg_cmd_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(Q_DEPTH)
    ) u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_data(q_wr_data),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_data(q_rd_data),
        .empty  (q_empty)
    );

    assign out_flags = cmd_flags_t'(q_rd_data[CMD_W-1 -: FLAGS_W]);
    assign out_top   = q_rd_data[4*NDIG +: DIG_IDX_W];
    assign out_bcd   = q_rd_data[4*NDIG-1:0];

    // byte sequencer and output beat
    mdtg_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_flags     (out_flags),
        .q_top       (out_top),
        .q_bcd       (out_bcd),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .md_byte     (md_byte),
        .last_of_item(last_of_item),
        .end_of_tag  (end_of_tag)
    );

endmodule
